// ----- hdl/fdp_pkg.sv -----
package fdp_pkg;

	// field and internal widths
	localparam int TIME_W = 64;
	localparam int RATE_W = 16;
	// period never exceeds one second in ns, which fits in 30 bits
	localparam int PER_W = 30;
	localparam int CNT_W = $clog2(TIME_W + 1);

	localparam int NS_PER_SEC = 1000000000;
	localparam int RATE_RESET = 30;

	// request to the serial divider
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
	} div_req_t;

endpackage

// ----- hdl/fdp_div.sv -----
module fdp_div import fdp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [TIME_W-1:0] dividend,
	input  logic [PER_W-1:0]  divisor,
	output logic              done,
	output logic [TIME_W-1:0] quotient,
	output logic [PER_W-1:0]  remainder
);

	logic [TIME_W-1:0] dvd_q;
	logic [PER_W-1:0]  rem_q;
	logic [PER_W-1:0]  dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [PER_W:0]    trial;
	logic [PER_W+1:0]  diff;
	logic              ge;

	// one restoring step: bring in the next dividend bit, try the subtract
	always_comb begin
		trial = {rem_q, dvd_q[TIME_W-1]};
		diff  = {1'b0, trial} - {2'b0, dsr_q};
		ge    = !diff[PER_W+1];
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[TIME_W-2:0], ge};
			rem_q <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ----- hdl/frame_deadline_pacer.sv -----
// Frame pacer: each query word (kind 0) carries a nanosecond timestamp and
// returns frame_due = 1 when a frame should be produced, re-arming the
// deadline at now plus one period when the rate changed or nothing is armed,
// and otherwise catching up by whole periods past now (deadlines saturate at
// all ones). A clear word (kind 1) drops the armed deadline and returns 0.
// The period, ceil(1e9 / rate) with rate 0 read as 1, and the catch-up
// remainder come from one shared bit-serial divider, one quotient bit per
// cycle. A clear skips the divider, an arming or not-due query runs it for
// the period (30 divider steps), and a catch-up query runs it again for the
// remainder (64 divider steps). One word is in flight at a time; the
// result sits in an output register so the next word can be taken while it
// waits. frames_per_second may be written only while the block is idle.
module frame_deadline_pacer import fdp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [TIME_W-1:0] now_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              frame_due,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_wdata
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PDIV = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_RDIV = 7'b0001000,
		S_SUB  = 7'b0010000,
		S_ADD  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [RATE_W-1:0] fps_q;
	logic [RATE_W-1:0] armed_q;
	logic [TIME_W-1:0] dl_q;
	logic [RATE_W-1:0] rate_q;
	logic [TIME_W-1:0] now_q;
	logic [PER_W-1:0]  period_q;
	logic [TIME_W-1:0] base_q;
	logic              res_q;
	logic              out_valid_q;
	logic              due_q;

	logic [RATE_W-1:0] eff;
	logic [PER_W-1:0]  pdiv_num;
	logic              rearm;
	logic              early;
	logic              catch_up;
	logic [TIME_W-1:0] lag;
	logic [TIME_W:0]   sum;

	div_req_t          div_req;
	logic [TIME_W-1:0] div_dividend;
	logic [PER_W-1:0]  div_divisor;
	logic              div_done;
	logic [TIME_W-1:0] div_quot;
	logic [PER_W-1:0]  div_rem;

	// effective rate and the rounded-up numerator for the period
	always_comb begin
		eff      = (fps_q == '0) ? RATE_W'(1) : fps_q;
		pdiv_num = PER_W'(NS_PER_SEC) + PER_W'(eff) - PER_W'(1);
	end

	// deadline decision
	always_comb begin
		rearm    = (armed_q != rate_q) || (dl_q == '0);
		early    = (now_q < dl_q);
		catch_up = (state_q == S_CHK) && !rearm && !early;
		lag      = now_q - dl_q;
		sum      = {1'b0, base_q} + {{(TIME_W + 1 - PER_W){1'b0}}, period_q};
	end

	// divider requests: period on a query accept, lag remainder on catch-up
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = CNT_W'(PER_W);
		div_dividend  = {pdiv_num, {(TIME_W - PER_W){1'b0}}};
		div_divisor   = {{(PER_W - RATE_W){1'b0}}, eff};
		if (catch_up) begin
			div_req.start = 1'b1;
			div_req.steps = CNT_W'(TIME_W);
			div_dividend  = lag;
			div_divisor   = period_q;
		end else if ((state_q == S_IDLE) && in_valid && !kind) begin
			div_req.start = 1'b1;
		end
	end

	fdp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q <= RATE_W'(RATE_RESET);
		end else if (cfg_we) begin
			fps_q <= cfg_wdata;
		end
	end

	// sequencer and pacing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			armed_q     <= '0;
			dl_q        <= '0;
			res_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind) begin
							dl_q    <= '0;
							armed_q <= '0;
							res_q   <= 1'b0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_PDIV;
						end
					end
				end
				S_PDIV: begin
					if (div_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (rearm) begin
						armed_q <= rate_q;
						state_q <= S_ADD;
					end else if (early) begin
						res_q   <= 1'b0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_RDIV;
					end
				end
				S_RDIV: begin
					if (div_done) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					dl_q    <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
					res_q   <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			due_q       <= 1'b0;
		end else if ((state_q == S_FIN) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
			due_q       <= res_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// word payload and arithmetic operands
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			now_q  <= now_time;
			rate_q <= eff;
		end
		if ((state_q == S_PDIV) && div_done) begin
			period_q <= div_quot[PER_W-1:0];
		end
		// arming adds the period to now; catch-up adds it to now less the remainder
		if ((state_q == S_CHK) && rearm) begin
			base_q <= now_q;
		end else if (state_q == S_SUB) begin
			base_q <= now_q - {{(TIME_W - PER_W){1'b0}}, div_rem};
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign frame_due = due_q;

endmodule
